@@ hw/rtl/nsrt_pkg.sv @@
// ----------------------------------------------------------------------------
// nsrt_pkg: shared types and constants for the neighbor status rate table
// Operation and status codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package nsrt_pkg;

  localparam int MAX_NEIGHBORS_DEF = 16;
  localparam int RATE_BITS_DEF     = 32;

  localparam int ID_W      = 16;
  localparam int IN_RATE_W = 32;
  localparam int LIMIT_W   = 32;
  localparam int TOTAL_W   = 36;
  localparam int STATUS_W  = 2;
  localparam int OP_W      = 3;
  localparam int LOWER_W   = 2;
  localparam int FLAGS_W   = 2;

  localparam logic [LIMIT_W-1:0] THRESHOLD_RESET = 32'hFFFF_FFFF;
  localparam logic [LOWER_W-1:0] LOWER_SAT       = 2'd2;
  localparam logic [FLAGS_W-1:0] FLAG_PUSHBACK   = 2'b01;
  localparam logic [FLAGS_W-1:0] FLAG_REFRESH    = 2'b10;

  typedef enum logic [OP_W-1:0] {
    OP_ADD         = 3'd0,
    OP_PUSHBACK    = 3'd1,
    OP_REFRESH     = 3'd2,
    OP_REGISTER    = 3'd3,
    OP_RESET       = 3'd4,
    OP_CONSOLIDATE = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 2'd0,
    ST_NOT_FOUND      = 2'd1,
    ST_FULL           = 2'd2,
    ST_NEVER_REPORTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RESP
  } state_t;

  typedef struct packed {
    op_t     op;
    status_t out_status;
    logic    load_in;
    logic    scan_start;
    logic    write_upd;
    logic    write_add;
    logic    clear_rep;
    logic    commit_cons;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hit;
    logic free_found;
    logic cons_err;
  } stat_t;

endpackage

@@ hw/rtl/nsrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// nsrt_ctrl: sequencer for the neighbor status rate table
// Accepts one beat at a time, runs the table scan, picks the action and the
// status code, and hands the result to the output register.
// ----------------------------------------------------------------------------
module nsrt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  nsrt_pkg::op_t    s_op,
  output logic             m_tvalid,
  input  logic             m_tready,
  output nsrt_pkg::cmd_t   cmd,
  input  nsrt_pkg::stat_t  stat
);
  import nsrt_pkg::*;

  state_t  state, state_next;
  op_t     op_q;
  status_t status_q, status_next;
  logic    out_valid;
  logic    accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= s_op;
    end
    if (state == S_DECIDE) begin
      status_q <= status_next;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;

  always_comb begin
    state_next      = state;
    status_next     = ST_OK;
    cmd             = '0;
    cmd.op          = op_q;
    cmd.out_status  = status_q;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          case (s_op)
            OP_ADD, OP_PUSHBACK, OP_REFRESH, OP_REGISTER, OP_CONSOLIDATE: begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            default: begin
              state_next = S_DECIDE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_RESP;
        case (op_q)
          OP_ADD: begin
            if (stat.hit) begin
              status_next = ST_OK;
            end else if (stat.free_found) begin
              cmd.write_add = 1'b1;
            end else begin
              status_next = ST_FULL;
            end
          end
          OP_PUSHBACK, OP_REFRESH, OP_REGISTER: begin
            if (stat.hit) begin
              cmd.write_upd = 1'b1;
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
          OP_RESET: begin
            cmd.clear_rep = 1'b1;
          end
          OP_CONSOLIDATE: begin
            if (stat.cons_err) begin
              status_next = ST_NEVER_REPORTED;
            end else begin
              cmd.commit_cons = 1'b1;
            end
          end
          default: begin
            status_next = ST_OK;
          end
        endcase
      end
      S_RESP: begin
        if (!out_valid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/nsrt_datapath.sv @@
// ----------------------------------------------------------------------------
// nsrt_datapath: entry store, scan pipeline and update logic
// Entry fields sit in memories read one entry per cycle by the scan; valid,
// rate-known and reported bits are flip-flops cleared at reset.
// ----------------------------------------------------------------------------
module nsrt_datapath #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int RATE_BITS     = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nsrt_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  logic [nsrt_pkg::ID_W-1:0]      in_id,
  input  logic [nsrt_pkg::IN_RATE_W-1:0] in_rate,
  input  logic [nsrt_pkg::LIMIT_W-1:0]   in_limit,
  input  nsrt_pkg::cmd_t                 cmd,
  output nsrt_pkg::stat_t                stat,
  output nsrt_pkg::status_t              out_status,
  output logic                           out_all,
  output logic [nsrt_pkg::TOTAL_W-1:0]   out_total
);
  import nsrt_pkg::*;

  localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int SUM_W = ((RATE_BITS > TOTAL_W) ? RATE_BITS : TOTAL_W) + 1;
  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(MAX_NEIGHBORS - 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  logic [LIMIT_W-1:0]   threshold;
  logic [ID_W-1:0]      id_q;
  logic [RATE_BITS-1:0] rate_q;
  logic [LIMIT_W-1:0]   limit_q;

  logic [ID_W-1:0]      mem_id    [MAX_NEIGHBORS];
  logic [LIMIT_W-1:0]   mem_limit [MAX_NEIGHBORS];
  logic [RATE_BITS-1:0] mem_rate  [MAX_NEIGHBORS];
  logic [LOWER_W-1:0]   mem_lower [MAX_NEIGHBORS];
  logic [FLAGS_W-1:0]   mem_flags [MAX_NEIGHBORS];

  logic [MAX_NEIGHBORS-1:0] valid, known, reported;

  logic [ID_W-1:0]      rd_id;
  logic [LIMIT_W-1:0]   rd_limit;
  logic [RATE_BITS-1:0] rd_rate;
  logic [LOWER_W-1:0]   rd_lower;
  logic [FLAGS_W-1:0]   rd_flags;

  logic [IDX_W-1:0] scan_idx, eval_idx;
  logic             scan_busy, eval_valid, eval_last;

  logic                 hit_q, free_q, err_q, all_q;
  logic [IDX_W-1:0]     hit_idx, free_idx;
  logic [LIMIT_W-1:0]   hit_limit;
  logic [RATE_BITS-1:0] hit_rate;
  logic [LOWER_W-1:0]   hit_lower;
  logic [FLAGS_W-1:0]   hit_flags;
  logic [TOTAL_W-1:0]   sum_q;

  logic                 all_reported_reg;
  logic [TOTAL_W-1:0]   total_rate_reg;

  logic is_find, is_cons, ev_ent, ev_known, ev_rep, ev_hit, ev_err, ev_stop;
  logic [SUM_W-1:0]     sum_add;
  logic [TOTAL_W-1:0]   sum_sat;

  logic [LIMIT_W-1:0]   upd_limit;
  logic [RATE_BITS-1:0] upd_rate, avg_rate;
  logic [LOWER_W-1:0]   upd_lower, lower_inc;
  logic [FLAGS_W-1:0]   upd_flags;

  // Configuration and input capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      id_q    <= in_id;
      rate_q  <= RATE_BITS'(in_rate);
      limit_q <= in_limit;
    end
  end

  // Scan evaluation: one entry per cycle, in the cycle after its read address is issued.
  always_comb begin
    is_find  = (cmd.op == OP_ADD) || (cmd.op == OP_PUSHBACK) ||
               (cmd.op == OP_REFRESH) || (cmd.op == OP_REGISTER);
    is_cons  = (cmd.op == OP_CONSOLIDATE);
    ev_ent   = valid[eval_idx];
    ev_known = known[eval_idx];
    ev_rep   = reported[eval_idx];
    ev_hit   = eval_valid && is_find && ev_ent && (rd_id == id_q);
    ev_err   = eval_valid && is_cons && ev_ent && !ev_rep && !ev_known;
    ev_stop  = ev_hit || ev_err;
    sum_add  = SUM_W'(sum_q) + SUM_W'(rd_rate);
    sum_sat  = (sum_add > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_add[TOTAL_W-1:0];
  end

  assign stat.scan_done  = eval_valid && (eval_last || ev_stop);
  assign stat.hit        = hit_q;
  assign stat.free_found = free_q;
  assign stat.cons_err   = err_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_busy  <= 1'b0;
      eval_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_busy  <= 1'b1;
      eval_valid <= 1'b0;
    end else begin
      eval_valid <= scan_busy && !ev_stop;
      if (ev_stop || (scan_busy && (scan_idx == LAST_IDX))) begin
        scan_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (scan_busy && (scan_idx != LAST_IDX)) begin
      scan_idx <= scan_idx + 1'b1;
    end
    eval_idx  <= scan_idx;
    eval_last <= (scan_idx == LAST_IDX);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      err_q  <= 1'b0;
      all_q  <= 1'b1;
      sum_q  <= '0;
    end else if (eval_valid) begin
      if (ev_hit) begin
        hit_q     <= 1'b1;
        hit_idx   <= eval_idx;
        hit_limit <= rd_limit;
        hit_rate  <= rd_rate;
        hit_lower <= rd_lower;
        hit_flags <= rd_flags;
      end
      if (ev_err) begin
        err_q <= 1'b1;
      end
      if (is_find && !ev_ent && !free_q) begin
        free_q   <= 1'b1;
        free_idx <= eval_idx;
      end
      if (is_cons && ev_ent && !ev_err) begin
        if (!ev_rep) begin
          all_q <= 1'b0;
        end
        if (ev_known) begin
          sum_q <= sum_sat;
        end
      end
    end
  end

  // New field values for a pushback, refresh or status report on the hit entry.
  always_comb begin
    avg_rate  = (hit_rate >> 1) + (rate_q >> 1) +
                RATE_BITS'(hit_rate[0] & rate_q[0]);
    lower_inc = (hit_lower < LOWER_SAT) ? hit_lower + 1'b1 : hit_lower;
    upd_limit = hit_limit;
    upd_rate  = hit_rate;
    upd_lower = hit_lower;
    upd_flags = hit_flags;
    case (cmd.op)
      OP_PUSHBACK: begin
        upd_flags = hit_flags | FLAG_PUSHBACK;
        upd_limit = limit_q;
        upd_rate  = rate_q;
      end
      OP_REFRESH: begin
        upd_flags = hit_flags | FLAG_REFRESH;
        upd_limit = limit_q;
      end
      OP_REGISTER: begin
        if ((hit_limit < threshold) || !known[hit_idx] || (rate_q >= hit_rate)) begin
          upd_rate  = rate_q;
          upd_lower = '0;
        end else begin
          upd_lower = lower_inc;
          if (lower_inc >= LOWER_SAT) begin
            upd_rate = avg_rate;
          end
        end
      end
      default: begin
        upd_flags = hit_flags;
      end
    endcase
  end

  // Entry memories: one write port, one registered read port at the scan address.
  always_ff @(posedge clk) begin
    if (cmd.write_upd) begin
      mem_limit[hit_idx] <= upd_limit;
      mem_rate[hit_idx]  <= upd_rate;
      mem_lower[hit_idx] <= upd_lower;
      mem_flags[hit_idx] <= upd_flags;
    end else if (cmd.write_add) begin
      mem_id[free_idx]    <= id_q;
      mem_limit[free_idx] <= '0;
      mem_rate[free_idx]  <= '0;
      mem_lower[free_idx] <= '0;
      mem_flags[free_idx] <= '0;
    end
    rd_id    <= mem_id[scan_idx];
    rd_limit <= mem_limit[scan_idx];
    rd_rate  <= mem_rate[scan_idx];
    rd_lower <= mem_lower[scan_idx];
    rd_flags <= mem_flags[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid            <= '0;
      known            <= '0;
      reported         <= '0;
      all_reported_reg <= 1'b0;
      total_rate_reg   <= '0;
    end else begin
      if (cmd.write_add) begin
        valid[free_idx]    <= 1'b1;
        known[free_idx]    <= 1'b0;
        reported[free_idx] <= 1'b0;
      end
      if (cmd.write_upd) begin
        if ((cmd.op == OP_PUSHBACK) || (cmd.op == OP_REGISTER)) begin
          known[hit_idx] <= 1'b1;
        end
        if (cmd.op == OP_REGISTER) begin
          reported[hit_idx] <= 1'b1;
        end
      end
      if (cmd.clear_rep) begin
        reported <= '0;
      end
      if (cmd.commit_cons) begin
        all_reported_reg <= all_q;
        total_rate_reg   <= sum_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= cmd.out_status;
      out_all    <= all_reported_reg;
      out_total  <= total_rate_reg;
    end
  end

endmodule

@@ hw/rtl/neighbor_status_rate_table.sv @@
// ----------------------------------------------------------------------------
// neighbor_status_rate_table: upstream neighbor table for rate pushback
// Keeps per-neighbor limits and status rates and consolidates a status round.
// ----------------------------------------------------------------------------
// Each input beat on the s_ channel carries one operation in s_tuser and its
// operands in s_tdata; each one gives exactly one result beat on m_, with the
// status code and the all-reported flag and total rate of the last good
// consolidate. The limit threshold is written through cfg_we/cfg_wdata, by
// the user only while the block is idle; the block does not enforce this.
// One beat is handled at a time. Operations that search the table (add,
// pushback, refresh, register, consolidate) run a scan that reads one entry
// per cycle from the entry memory and stops early when a lookup hits or a
// consolidate meets a never-reported entry. Reset status and unused codes
// skip the scan and go straight to the decision. The next beat is taken
// the cycle after the result is placed in the output register, so no new
// beat is accepted while the previous one is still in the engine.
// Reset empties the table at once: valid, rate-known and reported bits are
// flip-flops, while the entry fields in memory stay undefined until written.
// A stalled receiver holds the result in the output register; one finished
// operation can wait there while the next beat is accepted and processed.
module neighbor_status_rate_table #(
  parameter int MAX_NEIGHBORS = nsrt_pkg::MAX_NEIGHBORS_DEF,
  parameter int RATE_BITS     = nsrt_pkg::RATE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,    // limit_threshold
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,      // neighbor_id[15:0], rate_value[47:16], limit_value[79:48]
  input  logic [2:0]  s_tuser,      // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata       // status[1:0], all_reported[2], total_rate[38:3], zero[39]
);
  import nsrt_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  status_t out_status;
  logic    out_all;
  logic [TOTAL_W-1:0] out_total;

  nsrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_op     (op_t'(s_tuser)),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  nsrt_datapath #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .RATE_BITS     (RATE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_id      (s_tdata[15:0]),
    .in_rate    (s_tdata[47:16]),
    .in_limit   (s_tdata[79:48]),
    .cmd        (cmd),
    .stat       (stat),
    .out_status (out_status),
    .out_all    (out_all),
    .out_total  (out_total)
  );

  assign m_tdata = {1'b0, out_total, out_all, out_status};

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the neighbor status rate table
// A driver feeds operation beats from a pending queue and a monitor checks
// every result beat against a behavioral copy of the table, over several
// limit thresholds and several patterns of idling on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
  import nsrt_pkg::*;

  // Sizes and run control.
  localparam int MAX_NB       = MAX_NEIGHBORS_DEF;
  localparam int PHASE_ITEMS  = 270;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_CYCLES  = 300;
  // The slowest correct run is about 1100 beats, plus the receiver stalls at
  // 77 percent idling; this limit is many times that.
  localparam int LIMIT_CYCLES = 400000;

  // Codes the block treats as no operation; they must still give a result.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic [TOTAL_W-1:0] TOTAL_SAT = {TOTAL_W{1'b1}};

  // One operation beat as the driver sees it.
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [ID_W-1:0]      id;
    logic [IN_RATE_W-1:0] rate;
    logic [LIMIT_W-1:0]   lim;
  } nb_item_t;

  // One result beat, field by field.
  typedef struct packed {
    status_t            status;
    logic               all_rep;
    logic [TOTAL_W-1:0] total;
  } nb_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;      // neighbor_id[15:0], rate_value[47:16], limit_value[79:48]
  logic [2:0]  s_tuser = '0;      // operation[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // status[1:0], all_reported[2], total_rate[38:3], zero[39]

  neighbor_status_rate_table u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  // Beats waiting to be offered, and results owed by the block, oldest first.
  nb_item_t   ops_pending[$];
  nb_result_t results_due[$];

  // Idling percentages for the two sides, changed by the sequence between
  // phases. start_hold asks the receiver for one long stall.
  int   tx_idle_pct = 9;
  int   rx_idle_pct = 77;
  logic start_hold  = 1'b0;

  int mismatch_count = 0;
  int cycle_count    = 0;

  // Ids the random part works on; the first four exercise every id bit.
  logic [ID_W-1:0] tbl_ids[MAX_NB];

  // ---------------------------------------------------------------------------
  // Behavioral copy of the table. Ids are only read for valid entries, so
  // they need no reset value.
  // ---------------------------------------------------------------------------
  logic [LIMIT_W-1:0]   cfg_threshold = THRESHOLD_RESET;
  logic [ID_W-1:0]      nb_id[MAX_NB];
  logic                 nb_valid[MAX_NB];
  logic [LIMIT_W-1:0]   nb_limit[MAX_NB];
  logic [IN_RATE_W-1:0] nb_rate[MAX_NB];
  logic                 nb_known[MAX_NB];
  logic                 nb_reported[MAX_NB];
  logic [LOWER_W-1:0]   nb_lower[MAX_NB];
  logic                 round_all_rep = 1'b0;
  logic [TOTAL_W-1:0]   round_total = '0;

  function automatic int find_neighbor(logic [ID_W-1:0] id);
    int hit;
    hit = -1;
    for (int i = 0; i < MAX_NB; i++) begin
      if (hit < 0 && nb_valid[i] && nb_id[i] == id) hit = i;
    end
    return hit;
  endfunction

  // Applies one accepted operation to the table copy and returns the result
  // beat the block owes for it.
  function automatic nb_result_t table_apply(nb_item_t it);
    int                 idx;
    logic [IN_RATE_W:0] pair_sum;
    logic [TOTAL_W:0]   sum;
    logic               all_rep;
    logic               blocked;
    nb_result_t         res;
    res.status = ST_OK;
    case (it.op)
      OP_ADD: begin
        // A duplicate add changes nothing and still answers ok.
        if (find_neighbor(it.id) < 0) begin
          idx = -1;
          for (int i = 0; i < MAX_NB; i++) begin
            if (idx < 0 && !nb_valid[i]) idx = i;
          end
          if (idx < 0) begin
            res.status = ST_FULL;
          end else begin
            nb_valid[idx]    = 1'b1;
            nb_id[idx]       = it.id;
            nb_limit[idx]    = '0;
            nb_rate[idx]     = '0;
            nb_known[idx]    = 1'b0;
            nb_reported[idx] = 1'b0;
            nb_lower[idx]    = '0;
          end
        end
      end
      OP_PUSHBACK, OP_REFRESH, OP_REGISTER: begin
        idx = find_neighbor(it.id);
        if (idx < 0) begin
          res.status = ST_NOT_FOUND;
        end else if (it.op == OP_PUSHBACK) begin
          nb_limit[idx] = it.lim;
          nb_rate[idx]  = it.rate;
          nb_known[idx] = 1'b1;
        end else if (it.op == OP_REFRESH) begin
          nb_limit[idx] = it.lim;
        end else begin
          nb_reported[idx] = 1'b1;
          if (nb_limit[idx] < cfg_threshold || !nb_known[idx] || it.rate >= nb_rate[idx]) begin
            nb_rate[idx]  = it.rate;
            nb_known[idx] = 1'b1;
            nb_lower[idx] = '0;
          end else begin
            // Unlimited neighbor reporting less: only after repeated lower
            // reports does the rate move, to the floor of the mean.
            if (nb_lower[idx] < LOWER_SAT) nb_lower[idx] = nb_lower[idx] + 1'b1;
            if (nb_lower[idx] >= LOWER_SAT) begin
              pair_sum     = {1'b0, nb_rate[idx]} + {1'b0, it.rate};
              nb_rate[idx] = pair_sum[IN_RATE_W:1];
            end
          end
        end
      end
      OP_RESET: begin
        for (int i = 0; i < MAX_NB; i++) nb_reported[i] = 1'b0;
      end
      OP_CONSOLIDATE: begin
        sum     = '0;
        all_rep = 1'b1;
        blocked = 1'b0;
        for (int i = 0; i < MAX_NB; i++) begin
          if (nb_valid[i] && !blocked) begin
            if (!nb_reported[i]) begin
              if (!nb_known[i]) blocked = 1'b1;
              all_rep = 1'b0;
            end
            if (nb_known[i]) begin
              sum = sum + nb_rate[i];
              if (sum > TOTAL_SAT) sum = TOTAL_SAT;
            end
          end
        end
        // An entry that never had a rate leaves the round registers alone.
        if (blocked) begin
          res.status = ST_NEVER_REPORTED;
        end else begin
          round_all_rep = all_rep;
          round_total   = sum[TOTAL_W-1:0];
        end
      end
      default: ;
    endcase
    res.all_rep = round_all_rep;
    res.total   = round_total;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: takes the next pending beat whenever the slot is free, idling at
  // the current sender rate. Each accepted beat is run through the table copy
  // at the edge that accepts it, so expectations stay in block order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    nb_item_t taken;
    nb_item_t next_up;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        taken.op   = s_tuser;
        taken.id   = s_tdata[15:0];
        taken.rate = s_tdata[47:16];
        taken.lim  = s_tdata[79:48];
        results_due.push_back(table_apply(taken));
      end
      if (!s_tvalid || s_tready) begin
        if (ops_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_up = ops_pending.pop_front();
          s_tuser <= next_up.op;
          s_tdata <= {next_up.lim, next_up.rate, next_up.id};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready at the current rate, plus one long hold-off on
  // request so the output register and the engine fill and s_tready drops.
  // ---------------------------------------------------------------------------
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (start_hold && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted result beat is matched against the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    nb_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result beat", 64'(m_tdata), 64'(0));
      end else begin
        want = results_due.pop_front();
        if (m_tdata[1:0] !== want.status)
          report_mismatch("status", 64'(m_tdata[1:0]), 64'(want.status));
        if (m_tdata[2] !== want.all_rep)
          report_mismatch("all_reported", 64'(m_tdata[2]), 64'(want.all_rep));
        if (m_tdata[38:3] !== want.total)
          report_mismatch("total_rate", 64'(m_tdata[38:3]), 64'(want.total));
      end
    end
  end

  // Watchdog for a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                          logic [IN_RATE_W-1:0] rate, logic [LIMIT_W-1:0] lim);
    nb_item_t it;
    it.op   = op;
    it.id   = id;
    it.rate = rate;
    it.lim  = lim;
    ops_pending.push_back(it);
  endtask

  // Returns once every beat is taken and answered, with a margin for the
  // engine to settle; called at a falling edge so queues are stable.
  task automatic wait_drained();
    while (ops_pending.size() != 0 || s_tvalid || results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(logic [LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_threshold = value;
    @(negedge clk);
  endtask

  // Rates cluster at the ends and at small values so lower reports, equal
  // reports and averaging all come up.
  function automatic logic [IN_RATE_W-1:0] pick_rate();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      4: return $urandom_range(1000);
      default: return 32'hFFFF_FF00 + $urandom_range(255);
    endcase
  endfunction

  // Limits land on both sides of the threshold and right on it.
  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(5))
      0: return '0;
      1: return cfg_threshold;
      2: return cfg_threshold - 1'b1;
      3: return cfg_threshold + 1'b1;
      4: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(99) < 85) return tbl_ids[$urandom_range(MAX_NB - 1)];
    return ID_W'($urandom_range(16'hFFFF));
  endfunction

  // Mostly status traffic on known neighbors, with adds that slowly fill the
  // table and regular round resets and consolidates.
  task automatic queue_random(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 6) queue_op(OP_ADD, pick_id(), $urandom, $urandom);
      else if (pick < 20) queue_op(OP_PUSHBACK, pick_id(), pick_rate(), pick_limit());
      else if (pick < 32) queue_op(OP_REFRESH, pick_id(), $urandom, pick_limit());
      else if (pick < 72) queue_op(OP_REGISTER, pick_id(), pick_rate(), $urandom);
      else if (pick < 79) queue_op(OP_RESET, ID_W'($urandom), $urandom, $urandom);
      else if (pick < 96) queue_op(OP_CONSOLIDATE, ID_W'($urandom), $urandom, $urandom);
      else queue_op($urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO, ID_W'($urandom),
                    $urandom, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < MAX_NB; i++) begin
      nb_valid[i]    = 1'b0;
      nb_limit[i]    = '0;
      nb_rate[i]     = '0;
      nb_known[i]    = 1'b0;
      nb_reported[i] = 1'b0;
      nb_lower[i]    = '0;
      tbl_ids[i]     = ID_W'($urandom_range(16'hFFFF));
    end
    tbl_ids[0] = 16'h0000;
    tbl_ids[1] = 16'hFFFF;
    tbl_ids[2] = 16'h5555;
    tbl_ids[3] = 16'hAAAA;

    // Directed part, under the reset threshold. An empty table consolidates
    // to zero with everyone reported, and the spare codes do nothing.
    queue_op(OP_CONSOLIDATE, 16'h0000, 32'h0, 32'h0);
    queue_op(OP_SPARE_LO, 16'h1234, $urandom, $urandom);
    queue_op(OP_SPARE_HI, 16'hEDCB, $urandom, $urandom);
    // Messages for neighbors that are not in the table.
    queue_op(OP_PUSHBACK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(OP_REFRESH, 16'h0000, 32'h0, 32'h0);
    queue_op(OP_REGISTER, 16'h0000, 32'h1, 32'h0);
    // Two neighbors, one of them added twice.
    queue_op(OP_ADD, 16'h0000, 32'h0, 32'h0);
    queue_op(OP_ADD, 16'hFFFF, 32'h0, 32'h0);
    queue_op(OP_ADD, 16'h0000, 32'h0, 32'h0);
    // Neither has a rate yet, so consolidate must refuse.
    queue_op(OP_CONSOLIDATE, 16'h0000, 32'h0, 32'h0);
    // Pushback gives a rate under a finite limit of zero.
    queue_op(OP_PUSHBACK, 16'h0000, 32'hFFFF_FFFF, 32'h0);
    queue_op(OP_REGISTER, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
    // Switch the second neighbor to an unlimited limit and report lower
    // rates: the first lower report holds, later ones average.
    queue_op(OP_REFRESH, 16'hFFFF, 32'h0, 32'hFFFF_FFFF);
    queue_op(OP_REGISTER, 16'hFFFF, 32'd100, 32'h0);
    queue_op(OP_REGISTER, 16'hFFFF, 32'd50, 32'h0);
    queue_op(OP_REGISTER, 16'hFFFF, 32'd0, 32'h0);
    queue_op(OP_REGISTER, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
    // Known but silent neighbor: consolidate works, not all reported.
    queue_op(OP_CONSOLIDATE, 16'h0000, 32'h0, 32'h0);
    queue_op(OP_RESET, 16'h0000, 32'h0, 32'h0);
    queue_op(OP_CONSOLIDATE, 16'h0000, 32'h0, 32'h0);
    queue_op(OP_REGISTER, 16'h0000, 32'h0, 32'h0);
    queue_op(OP_REGISTER, 16'hFFFF, 32'd7, 32'h0);
    queue_op(OP_CONSOLIDATE, 16'h0000, 32'h0, 32'h0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    wait_drained();

    // Threshold in the middle; the sender idles rarely, the receiver often.
    write_threshold(32'h8000_0000);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Threshold zero makes every limit unlimited; idling is swapped.
    tx_idle_pct = 77;
    rx_idle_pct = 9;
    write_threshold(32'h0000_0000);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Top threshold, no idling, and one long receiver hold-off while the
    // sender keeps offering beats.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_threshold(32'hFFFF_FFFF);
    start_hold = 1'b1;
    queue_random(PHASE_ITEMS);
    wait_drained();

    write_threshold($urandom);
    queue_random(PHASE_ITEMS);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
